### src/stp_pkg.sv
// Shared types and constants of the stepper step/direction generator.
package stp_pkg;

   localparam int VALUE_W    = 32;
   localparam int PERIOD_W   = 16;
   localparam int QCOUNT_W   = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      FUNC_TICK     = 3'd0,
      FUNC_MOVE     = 3'd1,
      FUNC_ENQUEUE  = 3'd2,
      FUNC_LOAD     = 3'd3,
      FUNC_ZERO_POS = 3'd4,
      FUNC_SET_POS  = 3'd5
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR  = CSR_IDX_W'(1);

   typedef struct packed {
      logic                      step_pulse;
      logic                      direction;
      logic                      enable_n;
      logic                      busy_res;
      logic signed [VALUE_W-1:0] position;
      logic signed [VALUE_W-1:0] steps_remaining;
      logic [QCOUNT_W-1:0]       queue_count;
      logic                      queue_overflow;
   } rsp_word_type;

endpackage

### src/stp_if.sv
// Channel interfaces: command words in, result words out, register writes.
interface stp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [2:0]                             func;
   logic signed [stp_pkg::VALUE_W-1:0]     value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface stp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   step_pulse;
   logic                                   direction;
   logic                                   enable_n;
   logic                                   busy_res;
   logic signed [stp_pkg::VALUE_W-1:0]     position;
   logic signed [stp_pkg::VALUE_W-1:0]     steps_remaining;
   logic [stp_pkg::QCOUNT_W-1:0]           queue_count;
   logic                                   queue_overflow;

   modport source (output valid, output step_pulse, output direction, output enable_n,
                   output busy_res, output position, output steps_remaining,
                   output queue_count, output queue_overflow, input ready);
   modport sink   (input valid, input step_pulse, input direction, input enable_n,
                   input busy_res, input position, input steps_remaining,
                   input queue_count, input queue_overflow, output ready);
endinterface

interface stp_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [stp_pkg::CSR_IDX_W-1:0]          index;
   logic [stp_pkg::CSR_DATA_W-1:0]         data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/stepper_step_dir_generator_queue.sv
// Stepper step/direction generator with a job FIFO held in a synchronous memory.
//
//  channel  dir  payload                                        taken when
//  req_ch   in   func, value                                    valid && ready
//  rsp_ch   out  pulse, direction, enable, position, remaining,  valid && ready
//                queue count, overflow
//  csr_ch   in   index, data                                    valid (ready is high)
//
// One word per cycle sustained while results are taken. Stage one issues the job
// memory read at the head pointer, stage two executes the command and writes the
// result register. An enqueue in execute that hits the address being read is
// forwarded. A stalled result holds stage two, which in turn holds req_ch ready
// low. Reset is synchronous and needs no sweep.
module stepper_step_dir_generator_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MICROSTEPS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   stp_req_if.sink   req_ch,
   stp_rsp_if.source rsp_ch,
   stp_csr_if.sink   csr_ch
);
   import stp_pkg::*;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int MS_W   = $clog2(MICROSTEPS + 1) + 1;
   localparam int PROD_W = VALUE_W + MS_W;
   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(64'sh8000_0000));
   localparam logic signed [MS_W-1:0]   MS_S    = MS_W'(MICROSTEPS);

   // configuration
   logic [PERIOD_W-1:0] period_ff;
   logic                invert_ff;

   // architectural state
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W-1:0] delay_ff, delay_in;
   logic [VALUE_W-1:0]  pos_ff, pos_in;
   logic                dir_ff, dir_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // stage two (execute) registers
   logic                s1_valid_ff;
   logic [2:0]          s1_func_ff;
   logic [VALUE_W-1:0]  s1_value_ff;
   logic [VALUE_W-1:0]  s1_move_ff;
   logic [VALUE_W-1:0]  rd_ff;
   logic                fwd_ff;
   logic [VALUE_W-1:0]  fwd_data_ff;

   // result register
   logic                rsp_valid_ff;
   rsp_word_type        rsp_ff, rsp_in;

   logic [VALUE_W-1:0]  job_mem [QUEUE_DEPTH];

   logic                s1_fire, s1_load, mem_we;
   logic [IDX_W-1:0]    head_nx, tail_nx;
   logic [VALUE_W-1:0]  rem_nx, pos_nx, job_data;
   logic [PERIOD_W-1:0] delay_nx;
   logic [CNT_W-1:0]    cnt_nx;
   logic                dir_nx;
   logic signed [PROD_W-1:0] prod;
   logic [VALUE_W-1:0]  move_val;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign s1_load      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // move scaling with saturation, done as the word enters
   always_comb begin
      prod = PROD_W'($signed(req_ch.value)) * PROD_W'(MS_S);
      priority if (prod > SAT_MAX) begin
         move_val = 32'h7FFF_FFFF;
      end else if (prod < SAT_MIN) begin
         move_val = 32'h8000_0000;
      end else begin
         move_val = prod[VALUE_W-1:0];
      end
   end

   assign job_data = fwd_ff ? fwd_data_ff : rd_ff;

   // execute
   always_comb begin
      logic up;
      logic busy_pre;
      func_type f;
      up       = !rem_ff[VALUE_W-1];
      busy_pre = (rem_ff != '0);
      f        = func_type'(s1_func_ff);
      rem_nx   = rem_ff;
      delay_nx = delay_ff;
      pos_nx   = pos_ff;
      dir_nx   = dir_ff;
      head_nx  = head_ff;
      tail_nx  = tail_ff;
      cnt_nx   = cnt_ff;
      mem_we   = 1'b0;
      rsp_in   = '0;
      unique case (f)
         FUNC_TICK: begin
            if (busy_pre) begin
               dir_nx = up ^ invert_ff;
               if (delay_ff >= period_ff) begin
                  rsp_in.step_pulse = 1'b1;
                  delay_nx = '0;
                  pos_nx   = up ? pos_ff + 1'b1 : pos_ff - 1'b1;
                  rem_nx   = up ? rem_ff - 1'b1 : rem_ff + 1'b1;
               end else begin
                  delay_nx = delay_ff + 1'b1;
               end
            end
         end
         FUNC_MOVE: rem_nx = s1_move_ff;
         FUNC_ENQUEUE: begin
            if (cnt_ff >= CNT_W'(QUEUE_DEPTH)) begin
               rsp_in.queue_overflow = 1'b1;
            end else begin
               mem_we  = 1'b1;
               tail_nx = next_slot(tail_ff);
               cnt_nx  = cnt_ff + 1'b1;
            end
         end
         FUNC_LOAD: begin
            if (cnt_ff != '0) begin
               rem_nx  = job_data;
               head_nx = next_slot(head_ff);
               cnt_nx  = cnt_ff - 1'b1;
            end else begin
               rem_nx = '0;
            end
         end
         FUNC_ZERO_POS: pos_nx = '0;
         FUNC_SET_POS:  pos_nx = s1_value_ff;
         default: ;
      endcase
      rsp_in.direction       = dir_nx;
      rsp_in.busy_res        = (f == FUNC_TICK) ? busy_pre : (rem_nx != '0);
      rsp_in.enable_n        = !rsp_in.busy_res;
      rsp_in.position        = pos_nx;
      rsp_in.steps_remaining = rem_nx;
      rsp_in.queue_count     = QCOUNT_W'(cnt_nx);
   end

   always_comb begin
      rem_in   = s1_fire ? rem_nx   : rem_ff;
      delay_in = s1_fire ? delay_nx : delay_ff;
      pos_in   = s1_fire ? pos_nx   : pos_ff;
      dir_in   = s1_fire ? dir_nx   : dir_ff;
      head_in  = s1_fire ? head_nx  : head_ff;
      tail_in  = s1_fire ? tail_nx  : tail_ff;
      cnt_in   = s1_fire ? cnt_nx   : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= '0;
         invert_ff    <= 1'b0;
         rem_ff       <= '0;
         delay_ff     <= '0;
         pos_ff       <= '0;
         dir_ff       <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            if (csr_ch.index == CSR_STEP_PERIOD) period_ff <= csr_ch.data[PERIOD_W-1:0];
            if (csr_ch.index == CSR_INVERT_DIR)  invert_ff <= csr_ch.data[0];
         end
         rem_ff   <= rem_in;
         delay_ff <= delay_in;
         pos_ff   <= pos_in;
         dir_ff   <= dir_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_func_ff  <= req_ch.func;
         s1_value_ff <= req_ch.value;
         s1_move_ff  <= move_val;
         // an enqueue retiring now writes the slot this word reads
         fwd_ff      <= s1_fire && mem_we && (tail_ff == head_in);
         fwd_data_ff <= s1_value_ff;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // job memory
   always_ff @(posedge clock) begin
      if (s1_fire && mem_we) begin
         job_mem[tail_ff] <= s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         rd_ff <= job_mem[head_in];
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.step_pulse      = rsp_ff.step_pulse;
   assign rsp_ch.direction       = rsp_ff.direction;
   assign rsp_ch.enable_n        = rsp_ff.enable_n;
   assign rsp_ch.busy_res        = rsp_ff.busy_res;
   assign rsp_ch.position        = rsp_ff.position;
   assign rsp_ch.steps_remaining = rsp_ff.steps_remaining;
   assign rsp_ch.queue_count     = rsp_ff.queue_count;
   assign rsp_ch.queue_overflow  = rsp_ff.queue_overflow;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("job count above queue depth");

   a_pulse_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.step_pulse |-> rsp_ff.busy_res && !rsp_ff.enable_n)
      else $error("step pulse without steps remaining");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("executed word left no result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled without a blocked result");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      s1_fire && mem_we |=> tail_ff != $past(tail_ff) || QUEUE_DEPTH == 1)
      else $error("enqueue did not advance tail");

endmodule

### sim/stepper_step_dir_generator_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stepper step/direction generator with its job FIFO.
module stepper_step_dir_generator_queue_tb;
   import stp_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int MICROSTEPS     = 16;
   localparam int PHASES         = 7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PERCENT   = 38;

   // spare func codes, decoded as no operation
   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]                func;
      logic signed [VALUE_W-1:0] value;
   } stepper_cmd_type;

   typedef struct {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stp_req_if req_ch ();
   stp_rsp_if rsp_ch ();
   stp_csr_if csr_ch ();

   logic                      drv_req_valid = 1'b0;
   logic [2:0]                drv_req_func  = FUNC_TICK;
   logic signed [VALUE_W-1:0] drv_req_value = '0;
   logic                      drv_rsp_ready = 1'b0;
   logic                      drv_csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]      drv_csr_index = '0;
   logic [CSR_DATA_W-1:0]     drv_csr_data  = '0;

   assign req_ch.valid = drv_req_valid;
   assign req_ch.func  = drv_req_func;
   assign req_ch.value = drv_req_value;
   assign rsp_ch.ready = drv_rsp_ready;
   assign csr_ch.valid = drv_csr_valid;
   assign csr_ch.index = drv_csr_index;
   assign csr_ch.data  = drv_csr_data;

   stepper_step_dir_generator_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MICROSTEPS (MICROSTEPS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   stepper_cmd_type command_backlog[$];
   reg_write_type   reg_writes[$];
   rsp_word_type    expected_words[$];
   int              mismatches = 0;
   int              planned    = 0;
   bit              calm       = 1'b0;
   int              idle_cycles = 0;

   int phase_period [PHASES] = '{0, 0, 1, 3, 65535, 2, 0};
   int phase_invert [PHASES] = '{0, 1, 0, 1, 0, 1, 0};
   int phase_quota  [PHASES] = '{230, 230, 230, 230, 60, 230, 230};

   // predictor state
   logic [PERIOD_W-1:0]       model_period = '0;
   logic                      model_invert = 1'b0;
   logic signed [VALUE_W-1:0] model_rem    = '0;
   logic [PERIOD_W-1:0]       model_delay  = '0;
   logic signed [VALUE_W-1:0] model_pos    = '0;
   logic                      model_dir    = 1'b0;
   logic signed [VALUE_W-1:0] model_jobs [QUEUE_DEPTH];
   int                        model_head   = 0;
   int                        model_tail   = 0;
   logic [QCOUNT_W-1:0]       model_count  = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type advance_stepper(input logic [2:0] f,
                                                     input logic signed [VALUE_W-1:0] v);
      rsp_word_type w;
      logic         up;
      logic         busy;
      longint       scaled;
      w    = '0;
      busy = (model_rem != 0);
      case (f)
         FUNC_TICK: begin
            if (model_rem != 0) begin
               up        = (model_rem > 0);
               model_dir = up ^ model_invert;
               if (model_delay >= model_period) begin
                  w.step_pulse = 1'b1;
                  model_delay  = '0;
                  if (up) begin
                     model_pos = model_pos + 1;
                     model_rem = model_rem - 1;
                  end else begin
                     model_pos = model_pos - 1;
                     model_rem = model_rem + 1;
                  end
               end else begin
                  model_delay = model_delay + 1'b1;
               end
            end
         end
         FUNC_MOVE: begin
            scaled = longint'(v) * MICROSTEPS;
            if (scaled > longint'(32'sh7fffffff))
               scaled = longint'(32'sh7fffffff);
            if (scaled < -longint'(64'h80000000))
               scaled = -longint'(64'h80000000);
            model_rem = scaled[VALUE_W-1:0];
         end
         FUNC_ENQUEUE: begin
            if (model_count >= QUEUE_DEPTH) begin
               w.queue_overflow = 1'b1;
            end else begin
               model_jobs[model_tail] = v;
               model_tail  = (model_tail == QUEUE_DEPTH - 1) ? 0 : model_tail + 1;
               model_count = model_count + 1'b1;
            end
         end
         FUNC_LOAD: begin
            if (model_count != 0) begin
               model_rem   = model_jobs[model_head];
               model_head  = (model_head == QUEUE_DEPTH - 1) ? 0 : model_head + 1;
               model_count = model_count - 1'b1;
            end else begin
               model_rem = '0;
            end
         end
         FUNC_ZERO_POS: model_pos = '0;
         FUNC_SET_POS:  model_pos = v;
         default: ;
      endcase
      // a tick judges enable on the count before it moved
      if (f != FUNC_TICK)
         busy = (model_rem != 0);
      w.direction       = model_dir;
      w.enable_n        = ~busy;
      w.busy_res        = busy;
      w.position        = model_pos;
      w.steps_remaining = model_rem;
      w.queue_count     = model_count;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic queue_command(input logic [2:0] f, input logic signed [VALUE_W-1:0] v);
      stepper_cmd_type c;
      c.func  = f;
      c.value = v;
      command_backlog.push_back(c);
      planned++;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_command(FUNC_TICK, $urandom);
   endtask

   // small step counts keep moves short; now and then a full-width word
   function automatic logic signed [VALUE_W-1:0] job_value();
      int s;
      if ($urandom_range(0, 4) == 0)
         return $urandom;
      s = $urandom_range(0, 200);
      return s - 100;
   endfunction

   task automatic plan_segment();
      int                        kind;
      int                        reps;
      int                        s;
      logic signed [VALUE_W-1:0] v;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            s = $urandom_range(0, 16);
            queue_command(FUNC_MOVE, s - 8);
            queue_ticks($urandom_range(4, 40));
         end
         3, 4: begin
            reps = $urandom_range(1, 20);
            repeat (reps) queue_command(FUNC_ENQUEUE, job_value());
            reps = $urandom_range(1, 6);
            repeat (reps) begin
               queue_command(FUNC_LOAD, $urandom);
               queue_ticks($urandom_range(0, 12));
            end
         end
         5: begin
            queue_command(FUNC_LOAD, $urandom);
            queue_ticks($urandom_range(2, 30));
         end
         6: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7fffffff - $urandom_range(0, 20);
               1: v = 32'h80000000 + $urandom_range(0, 20);
               2: v = $urandom;
               default: v = '0;
            endcase
            if ($urandom_range(0, 3) == 0)
               queue_command(FUNC_ZERO_POS, $urandom);
            else
               queue_command(FUNC_SET_POS, v);
            s = $urandom_range(0, 6);
            queue_command(FUNC_MOVE, s - 3);
            queue_ticks($urandom_range(2, 30));
         end
         7: begin
            queue_command(FUNC_MOVE, $urandom);
            queue_ticks($urandom_range(1, 8));
         end
         default: begin
            reps = $urandom_range(1, 8);
            repeat (reps) queue_command(3'($urandom_range(0, 7)), $urandom);
         end
      endcase
   endtask

   task automatic queue_directed();
      queue_command(FUNC_TICK, 32'sh0);
      queue_command(FUNC_MOVE, 32'sh0);
      queue_command(FUNC_MOVE, 32'sh1);
      queue_ticks(2);
      queue_command(FUNC_MOVE, -32'sh1);
      queue_ticks(2);
      queue_command(FUNC_MOVE, 32'sh7fffffff);
      queue_command(FUNC_TICK, 32'sh0);
      queue_command(FUNC_MOVE, 32'h80000000);
      queue_command(FUNC_TICK, -32'sh1);
      queue_command(FUNC_LOAD, 32'sh0);
      queue_command(FUNC_ENQUEUE, 32'sh7fffffff);
      queue_command(FUNC_ENQUEUE, 32'h80000000);
      queue_command(FUNC_LOAD, 32'sh0);
      queue_command(FUNC_TICK, 32'sh0);
      queue_command(FUNC_LOAD, 32'sh0);
      queue_command(FUNC_TICK, 32'sh0);
      queue_command(FUNC_SET_POS, 32'sh7fffffff);
      queue_command(FUNC_MOVE, 32'sh1);
      queue_command(FUNC_TICK, 32'sh0);
      queue_command(FUNC_ZERO_POS, -32'sh1);
      queue_command(FUNC_SET_POS, 32'h80000000);
      queue_command(FUNC_SPARE6, -32'sh1);
      queue_command(FUNC_SPARE7, 32'sh0);
   endtask

   // command channel driver
   always @(posedge clock) begin : command_driver
      stepper_cmd_type c;
      if (reset) begin
         drv_req_valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_words.push_back(advance_stepper(req_ch.func, req_ch.value));
         if (!req_ch.valid || req_ch.ready) begin
            if (command_backlog.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               c = command_backlog.pop_front();
               drv_req_valid <= 1'b1;
               drv_req_func  <= c.func;
               drv_req_value <= c.value;
            end else begin
               drv_req_valid <= 1'b0;
            end
         end
      end
   end

   // register write driver; writes only reach it while the block is idle
   always @(posedge clock) begin : reg_driver
      reg_write_type r;
      if (reset) begin
         drv_csr_valid <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_STEP_PERIOD)
               model_period = csr_ch.data[PERIOD_W-1:0];
            else if (csr_ch.index == CSR_INVERT_DIR)
               model_invert = csr_ch.data[0];
         end
         if (!csr_ch.valid || csr_ch.ready) begin
            if (reg_writes.size() != 0) begin
               r = reg_writes.pop_front();
               drv_csr_valid <= 1'b1;
               drv_csr_index <= r.index;
               drv_csr_data  <= r.data;
            end else begin
               drv_csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         drv_rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.step_pulse      = rsp_ch.step_pulse;
            got.direction       = rsp_ch.direction;
            got.enable_n        = rsp_ch.enable_n;
            got.busy_res        = rsp_ch.busy_res;
            got.position        = rsp_ch.position;
            got.steps_remaining = rsp_ch.steps_remaining;
            got.queue_count     = rsp_ch.queue_count;
            got.queue_overflow  = rsp_ch.queue_overflow;
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing outstanding", got.position, '0);
            end else begin
               want = expected_words.pop_front();
               if (got.step_pulse !== want.step_pulse)
                  report_mismatch("step_pulse", got.step_pulse, want.step_pulse);
               if (got.direction !== want.direction)
                  report_mismatch("direction", got.direction, want.direction);
               if (got.enable_n !== want.enable_n)
                  report_mismatch("enable_n", got.enable_n, want.enable_n);
               if (got.busy_res !== want.busy_res)
                  report_mismatch("busy_res", got.busy_res, want.busy_res);
               if (got.position !== want.position)
                  report_mismatch("position", got.position, want.position);
               if (got.steps_remaining !== want.steps_remaining)
                  report_mismatch("steps_remaining", got.steps_remaining,
                                  want.steps_remaining);
               if (got.queue_count !== want.queue_count)
                  report_mismatch("queue_count", got.queue_count, want.queue_count);
               if (got.queue_overflow !== want.queue_overflow)
                  report_mismatch("queue_overflow", got.queue_overflow,
                                  want.queue_overflow);
            end
         end
         drv_rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : sequencer
      reg_write_type r;
      int            ph;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < PHASES; ph++) begin
         @(negedge clock);
         // junk in the upper bits must be ignored
         r.index = CSR_STEP_PERIOD;
         r.data  = {16'($urandom), 16'(phase_period[ph])};
         reg_writes.push_back(r);
         r.index = CSR_INVERT_DIR;
         r.data  = {31'($urandom), 1'(phase_invert[ph])};
         reg_writes.push_back(r);
         while (reg_writes.size() != 0 || drv_csr_valid)
            @(negedge clock);
         calm    = (ph == 5);
         planned = 0;
         if (ph == 0)
            queue_directed();
         while (planned < phase_quota[ph])
            plan_segment();
         // hold the sender until every word of the phase is back
         while (command_backlog.size() != 0 || drv_req_valid || expected_words.size() != 0)
            @(negedge clock);
         calm = 1'b0;
      end
      repeat (6) @(negedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words still outstanding", expected_words.size(), '0);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
